// ===== sv/rrt_pkg.sv =====
`timescale 1ns / 1ps

package rrt_pkg;

  localparam int TIMER_BITS_DEF = 16;

  // Item functions
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_FRAME = 2'd2;

  // Transaction kinds
  localparam logic [2:0] KIND_NONE       = 3'd0;
  localparam logic [2:0] KIND_SET_READ   = 3'd1;
  localparam logic [2:0] KIND_SET_SEND   = 3'd2;
  localparam logic [2:0] KIND_STATE_SEND = 3'd3;
  localparam logic [2:0] KIND_CAL_READ   = 3'd4;
  localparam logic [2:0] KIND_CAL_SEND   = 3'd5;

  // Frame kinds
  localparam logic [2:0] FRAME_UNKNOWN   = 3'd0;
  localparam logic [2:0] FRAME_ACK_SET   = 3'd1;
  localparam logic [2:0] FRAME_ACK_STATE = 3'd2;
  localparam logic [2:0] FRAME_ACK_CAL   = 3'd3;
  localparam logic [2:0] FRAME_STATUS    = 3'd4;
  localparam logic [2:0] FRAME_SETTINGS  = 3'd5;
  localparam logic [2:0] FRAME_CALIB     = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_SHORT_IVL = 2'd0;
  localparam logic [1:0] CFG_LONG_IVL  = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIM = 2'd2;

  localparam logic [15:0] SHORT_IVL_RST = 16'd1000;
  localparam logic [15:0] LONG_IVL_RST  = 16'd2000;
  localparam logic [3:0]  RETRY_LIM_RST = 4'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] txn_kind;
    logic       clear_retries;
    logic [2:0] frame_kind;
  } in_item_t;

  typedef struct packed {
    logic       resend;
    logic [2:0] resend_kind;
    logic       gave_up;
    logic       show_error;
    logic       ack_taken;
    logic       settings_seen;
    logic       calib_seen;
    logic       status_shown;
    logic       frame_bad;
    logic       busy_res;
    logic       deaf;
    logic [3:0] retries_used;
  } out_item_t;

  typedef struct packed {
    logic [15:0] short_interval;
    logic [15:0] long_interval;
    logic [3:0]  retry_limit;
  } cfg_t;

  function automatic logic is_store(input logic [2:0] k);
    return (k == KIND_SET_SEND) || (k == KIND_CAL_SEND);
  endfunction

  // Send kind that an acknowledgement frame answers
  function automatic logic [2:0] ack_kind(input logic [2:0] fk);
    logic [2:0] k;
    case (fk)
      FRAME_ACK_SET:   k = KIND_SET_SEND;
      FRAME_ACK_STATE: k = KIND_STATE_SEND;
      FRAME_ACK_CAL:   k = KIND_CAL_SEND;
      default:         k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/rrt_outq.sv =====
`timescale 1ns / 1ps

module rrt_outq
  import rrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      has_space,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  out_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign has_space = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/rrt_core.sv =====
`timescale 1ns / 1ps

module rrt_core
  import rrt_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic [2:0]            pending_kind_r, pending_kind_nxt;
  logic [3:0]            retry_cnt_r, retry_cnt_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic [CMP_W-1:0]      elapsed_cmp, ivl_cmp;
  logic [15:0]           ivl;

  always_comb begin
    pending_kind_nxt = pending_kind_r;
    retry_cnt_nxt    = retry_cnt_r;
    elapsed_nxt      = elapsed_r;
    result           = '0;

    // The elapsed count sticks at its top, so a wider interval never expires.
    elapsed_inc = (elapsed_r != '1) ? elapsed_r + 1'b1 : elapsed_r;
    ivl         = is_store(pending_kind_r) ? cfg.long_interval : cfg.short_interval;
    elapsed_cmp = CMP_W'(elapsed_inc);
    ivl_cmp     = CMP_W'(ivl);

    case (item.func)
      FUNC_TICK: begin
        if (pending_kind_r != KIND_NONE) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_cmp >= ivl_cmp) begin
            result.resend_kind = pending_kind_r;
            if (retry_cnt_r < cfg.retry_limit) begin
              retry_cnt_nxt = retry_cnt_r + 4'd1;
              result.resend = 1'b1;
              elapsed_nxt   = '0;
            end else begin
              result.gave_up    = 1'b1;
              result.show_error = is_store(pending_kind_r) ||
                                  (pending_kind_r == KIND_STATE_SEND);
              pending_kind_nxt  = KIND_NONE;
              retry_cnt_nxt     = 4'd0;
            end
          end
        end
      end
      FUNC_START: begin
        if (item.txn_kind >= KIND_SET_READ && item.txn_kind <= KIND_CAL_SEND) begin
          pending_kind_nxt = item.txn_kind;
          elapsed_nxt      = '0;
          if (item.clear_retries) begin
            retry_cnt_nxt = 4'd0;
          end
        end
      end
      FUNC_FRAME: begin
        case (item.frame_kind)
          FRAME_ACK_SET, FRAME_ACK_STATE, FRAME_ACK_CAL: begin
            if (pending_kind_r != KIND_NONE &&
                ack_kind(item.frame_kind) == pending_kind_r) begin
              result.ack_taken = 1'b1;
              pending_kind_nxt = KIND_NONE;
              retry_cnt_nxt    = 4'd0;
            end else begin
              result.frame_bad = 1'b1;
            end
          end
          FRAME_STATUS: begin
            result.status_shown = (pending_kind_r == KIND_NONE);
          end
          FRAME_SETTINGS: begin
            result.settings_seen = 1'b1;
            if (pending_kind_r == KIND_SET_READ) begin
              pending_kind_nxt = KIND_NONE;
              retry_cnt_nxt    = 4'd0;
            end
          end
          FRAME_CALIB: begin
            result.calib_seen = 1'b1;
            if (pending_kind_r == KIND_CAL_READ) begin
              pending_kind_nxt = KIND_NONE;
              retry_cnt_nxt    = 4'd0;
            end
          end
          default: begin
            result.frame_bad = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase

    result.busy_res     = (pending_kind_nxt != KIND_NONE);
    result.deaf         = is_store(pending_kind_nxt);
    result.retries_used = retry_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_kind_r <= KIND_NONE;
      retry_cnt_r    <= 4'd0;
      elapsed_r      <= '0;
    end else if (fire) begin
      pending_kind_r <= pending_kind_nxt;
      retry_cnt_r    <= retry_cnt_nxt;
      elapsed_r      <= elapsed_nxt;
    end
  end

`ifndef SYNTHESIS
  a_give_up_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.gave_up |=> pending_kind_r == KIND_NONE && retry_cnt_r == 4'd0)
    else $error("abandoned transaction left state behind");

  a_resend_restarts_timer: assert property (@(posedge clk) disable iff (!rst_n)
    fire && result.resend |=> elapsed_r == '0)
    else $error("timer not restarted after resend");

  a_resend_xor_give_up: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !(result.resend && result.gave_up))
    else $error("resend and give-up in the same word");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(pending_kind_r) && $stable(retry_cnt_r) && $stable(elapsed_r))
    else $error("tracker state moved without an item");
`endif

endmodule

// ===== sv/request_retry_tracker.sv =====
`timescale 1ns / 1ps

// Retry tracker for one outstanding backend request. Each input word is a
// millisecond tick, a transaction start, a classified received frame or a
// no-op with an unused function code, and each produces exactly one result
// word. A word is registered on entry, evaluated against the tracker state
// and written to a two-word result queue, so one word is taken every clock
// cycle as long as results are drained; the result word is offered once its
// input word has passed the input register and the queue has taken it. The
// input stalls only when the result queue is full. Interval and retry
// limit registers may be written at any time the block holds no word.
module request_retry_tracker
  import rrt_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      q_space;
  logic      fire;
  out_item_t result;
  cfg_t      cfg_r, cfg_nxt;

  assign fire      = in_vld_r && q_space;
  assign in_stall  = in_vld_r && !q_space;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SHORT_IVL: cfg_nxt.short_interval = cfg_wdata;
        CFG_LONG_IVL:  cfg_nxt.long_interval  = cfg_wdata;
        CFG_RETRY_LIM: cfg_nxt.retry_limit    = cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_interval <= SHORT_IVL_RST;
      cfg_r.long_interval  <= LONG_IVL_RST;
      cfg_r.retry_limit    <= RETRY_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rrt_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .result(result)
  );

  rrt_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fire),
    .push_data(result),
    .has_space(q_space),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== tb/request_retry_tracker_tb.sv =====
`timescale 1ns / 1ps

module request_retry_tracker_tb;
  import rrt_pkg::*;

  // Codes that the block must treat as no-ops or as unknown.
  localparam logic [1:0] FUNC_NONE   = 2'd3;
  localparam logic [2:0] KIND_UNDEF  = 3'd7;
  localparam logic [2:0] FRAME_UNDEF = 3'd7;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  localparam int TIMER_W = TIMER_BITS_DEF;
  localparam logic [TIMER_W-1:0] TIMER_TOP = '1;

  class tracker_scoreboard;
    logic [15:0]        short_ivl;
    logic [15:0]        long_ivl;
    logic [3:0]         retry_lim;
    logic [2:0]         pend_kind;
    logic [3:0]         retries;
    logic [TIMER_W-1:0] elapsed;
    out_item_t          owed_results[$];
    int                 errors;

    function new();
      short_ivl = SHORT_IVL_RST;
      long_ivl  = LONG_IVL_RST;
      retry_lim = RETRY_LIM_RST;
      pend_kind = KIND_NONE;
      retries   = '0;
      elapsed   = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_SHORT_IVL: short_ivl = val;
        CFG_LONG_IVL:  long_ivl  = val;
        CFG_RETRY_LIM: retry_lim = val[3:0];
        default: ;
      endcase
    endfunction

    function int owed();
      return owed_results.size();
    endfunction

    function out_item_t track_word(in_item_t w);
      out_item_t   r;
      logic [15:0] ivl;
      logic        store;
      logic [2:0]  acked;
      r = '0;
      store = (pend_kind == KIND_SET_SEND) || (pend_kind == KIND_CAL_SEND);
      case (w.func)
        FUNC_TICK: begin
          if (pend_kind != KIND_NONE) begin
            ivl = store ? long_ivl : short_ivl;
            if (elapsed != TIMER_TOP) elapsed = elapsed + 1'b1;
            if (elapsed >= ivl) begin
              r.resend_kind = pend_kind;
              if (retries < retry_lim) begin
                retries  = retries + 1'b1;
                r.resend = 1'b1;
                elapsed  = '0;
              end else begin
                r.gave_up    = 1'b1;
                r.show_error = store || (pend_kind == KIND_STATE_SEND);
                pend_kind    = KIND_NONE;
                retries      = '0;
              end
            end
          end
        end
        FUNC_START: begin
          if (w.txn_kind >= KIND_SET_READ && w.txn_kind <= KIND_CAL_SEND) begin
            pend_kind = w.txn_kind;
            elapsed   = '0;
            if (w.clear_retries) retries = '0;
          end
        end
        FUNC_FRAME: begin
          case (w.frame_kind)
            FRAME_ACK_SET, FRAME_ACK_STATE, FRAME_ACK_CAL: begin
              acked = (w.frame_kind == FRAME_ACK_SET)   ? KIND_SET_SEND :
                      (w.frame_kind == FRAME_ACK_STATE) ? KIND_STATE_SEND : KIND_CAL_SEND;
              if (pend_kind != KIND_NONE && acked == pend_kind) begin
                r.ack_taken = 1'b1;
                pend_kind   = KIND_NONE;
                retries     = '0;
              end else begin
                r.frame_bad = 1'b1;
              end
            end
            FRAME_STATUS: r.status_shown = (pend_kind == KIND_NONE);
            FRAME_SETTINGS: begin
              r.settings_seen = 1'b1;
              if (pend_kind == KIND_SET_READ) begin
                pend_kind = KIND_NONE;
                retries   = '0;
              end
            end
            FRAME_CALIB: begin
              r.calib_seen = 1'b1;
              if (pend_kind == KIND_CAL_READ) begin
                pend_kind = KIND_NONE;
                retries   = '0;
              end
            end
            default: r.frame_bad = 1'b1;
          endcase
        end
        default: ;
      endcase
      r.busy_res     = (pend_kind != KIND_NONE);
      r.deaf         = (pend_kind == KIND_SET_SEND) || (pend_kind == KIND_CAL_SEND);
      r.retries_used = retries;
      return r;
    endfunction

    function void note_word(in_item_t w);
      owed_results.push_back(track_word(w));
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("%0t ns: %s", $time, msg);
    endtask

    task check_field(string name, logic [3:0] got, logic [3:0] want);
      if (got !== want) report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        report("result word arrived with nothing expected");
        return;
      end
      want = owed_results.pop_front();
      check_field("resend",        got.resend,        want.resend);
      check_field("resend_kind",   got.resend_kind,   want.resend_kind);
      check_field("gave_up",       got.gave_up,       want.gave_up);
      check_field("show_error",    got.show_error,    want.show_error);
      check_field("ack_taken",     got.ack_taken,     want.ack_taken);
      check_field("settings_seen", got.settings_seen, want.settings_seen);
      check_field("calib_seen",    got.calib_seen,    want.calib_seen);
      check_field("status_shown",  got.status_shown,  want.status_shown);
      check_field("frame_bad",     got.frame_bad,     want.frame_bad);
      check_field("busy_res",      got.busy_res,      want.busy_res);
      check_field("deaf",          got.deaf,          want.deaf);
      check_field("retries_used",  got.retries_used,  want.retries_used);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_SHORT_IVL;
  logic [15:0] cfg_wdata = '0;

  tracker_scoreboard sb;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  logic       rx_hold = 1'b0;
  logic [2:0] issued_kind = KIND_NONE;

  request_retry_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  function automatic in_item_t mk_word(logic [1:0] f, logic [2:0] k, logic c, logic [2:0] fk);
    in_item_t w;
    w.func          = f;
    w.txn_kind      = k;
    w.clear_retries = c;
    w.frame_kind    = fk;
    return w;
  endfunction

  // Mostly ticks, with starts and frames that half the time give the matching reply, and some noise.
  function automatic in_item_t next_word(int tick_w);
    in_item_t w;
    int       roll;
    w.func          = 2'($urandom_range(3));
    w.txn_kind      = 3'($urandom_range(7));
    w.clear_retries = 1'($urandom_range(1));
    w.frame_kind    = 3'($urandom_range(7));
    roll = $urandom_range(99);
    if (roll < tick_w) begin
      w.func = FUNC_TICK;
    end else if (roll < tick_w + (100 - tick_w) * 2 / 5) begin
      w.func = FUNC_START;
      if ($urandom_range(9) != 0) w.txn_kind = 3'($urandom_range(KIND_SET_READ, KIND_CAL_SEND));
      issued_kind = w.txn_kind;
    end else if (roll < 97) begin
      w.func = FUNC_FRAME;
      if ($urandom_range(1) != 0) begin
        case (issued_kind)
          KIND_SET_READ:   w.frame_kind = FRAME_SETTINGS;
          KIND_SET_SEND:   w.frame_kind = FRAME_ACK_SET;
          KIND_STATE_SEND: w.frame_kind = FRAME_ACK_STATE;
          KIND_CAL_READ:   w.frame_kind = FRAME_CALIB;
          KIND_CAL_SEND:   w.frame_kind = FRAME_ACK_CAL;
          default:         w.frame_kind = FRAME_STATUS;
        endcase
      end
    end else begin
      w.func = FUNC_NONE;
    end
    return w;
  endfunction

  // Called just after a falling edge; returns just after a falling edge with
  // the accepted word still on the port, to be replaced or dropped by the caller.
  task automatic drive_item(in_item_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.owed() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] s, logic [15:0] l, logic [3:0] lim);
    logic [15:0] lim_word;
    // The upper bits of the retry limit word should be ignored by the block.
    lim_word      = 16'($urandom);
    lim_word[3:0] = lim;
    write_reg(CFG_SHORT_IVL, s);
    write_reg(CFG_LONG_IVL, l);
    write_reg(CFG_RETRY_LIM, lim_word);
  endtask

  task automatic hold_receiver(int cycles);
    rx_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold = 1'b0;
  endtask

  task automatic run_random(int n, int tx_pct, int rx_pct, int tick_w, bit squeeze);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == n / 3) begin
        fork
          hold_receiver(80);
        join_none
      end
      if (squeeze && i == 2 * n / 3) begin
        in_valid <= 1'b0;
        while (sb.owed() != 0) @(posedge clk);
        @(negedge clk);
      end
      drive_item(next_word(tick_w));
    end
    settle();
  endtask

  initial begin
    #(20_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Under the reset settings: nothing here can time out.
    drive_item(mk_word(FUNC_TICK,  KIND_NONE,       1'b0, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_FRAME, KIND_NONE,       1'b0, FRAME_ACK_SET));
    drive_item(mk_word(FUNC_FRAME, KIND_NONE,       1'b0, FRAME_STATUS));
    drive_item(mk_word(FUNC_FRAME, KIND_NONE,       1'b0, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_FRAME, KIND_UNDEF,      1'b1, FRAME_UNDEF));
    drive_item(mk_word(FUNC_NONE,  KIND_UNDEF,      1'b1, FRAME_UNDEF));
    drive_item(mk_word(FUNC_START, KIND_NONE,       1'b1, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_START, KIND_UNDEF,      1'b1, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_START, KIND_SET_READ,   1'b1, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_FRAME, KIND_NONE,       1'b0, FRAME_STATUS));
    drive_item(mk_word(FUNC_FRAME, KIND_NONE,       1'b0, FRAME_CALIB));
    settle();

    // Short intervals of 1 and 3 and a single retry, so timeouts and give-ups show at once.
    set_config(16'd1, 16'd3, 4'd1);
    drive_item(mk_word(FUNC_TICK,  KIND_NONE,       1'b0, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_TICK,  KIND_NONE,       1'b0, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_START, KIND_STATE_SEND, 1'b0, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_FRAME, KIND_NONE,       1'b0, FRAME_ACK_SET));
    drive_item(mk_word(FUNC_TICK,  KIND_NONE,       1'b0, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_TICK,  KIND_NONE,       1'b0, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_START, KIND_CAL_SEND,   1'b1, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_START, KIND_SET_SEND,   1'b0, FRAME_UNKNOWN));
    repeat (3) drive_item(mk_word(FUNC_TICK, KIND_NONE, 1'b0, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_FRAME, KIND_NONE,       1'b0, FRAME_ACK_SET));
    drive_item(mk_word(FUNC_START, KIND_CAL_READ,   1'b0, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_FRAME, KIND_NONE,       1'b0, FRAME_CALIB));
    drive_item(mk_word(FUNC_START, KIND_CAL_SEND,   1'b1, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_FRAME, KIND_NONE,       1'b0, FRAME_ACK_CAL));
    settle();

    set_config(16'd3, 16'd7, 4'd2);
    run_random(300, 7, 66, 45, 1'b1);
    set_config(16'd1, 16'd1, 4'd0);
    run_random(200, 7, 66, 45, 1'b0);
    set_config(16'd2, 16'd5, 4'd15);
    run_random(300, 66, 7, 70, 1'b0);
    set_config(16'($urandom_range(1, 20)), 16'($urandom_range(1, 40)), 4'($urandom_range(15)));
    run_random(300, 66, 7, 50, 1'b0);
    set_config(16'd1, 16'd2, 4'd15);
    run_random(250, 0, 0, 80, 1'b0);
    set_config(16'hFFFF, 16'hFFFF, 4'd15);
    run_random(100, 0, 0, 50, 1'b0);

    // The store send runs through its whole long interval before it is
    // abandoned; the unused register index must leave the settings alone.
    set_config(16'd2, 16'd40, 4'd0);
    write_reg(CFG_UNUSED, 16'($urandom));
    drive_item(mk_word(FUNC_START, KIND_CAL_SEND, 1'b1, FRAME_UNKNOWN));
    repeat (40) drive_item(mk_word(FUNC_TICK, KIND_NONE, 1'b0, FRAME_UNKNOWN));
    drive_item(mk_word(FUNC_START, KIND_STATE_SEND, 1'b0, FRAME_UNKNOWN));
    repeat (3) drive_item(mk_word(FUNC_TICK, KIND_NONE, 1'b0, FRAME_UNKNOWN));
    settle();

    if (sb.owed() != 0) sb.report($sformatf("%0d result words never arrived", sb.owed()));
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
